>>> design/rbv_pkg.sv
// Shared widths, register indexes and pipeline control types for the rotation block.
package rbv_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 14;

    // Components are scaled down until the largest magnitude is at most this.
    localparam int PRESCALE_LIMIT = 16384;

    localparam int PC_W   = 16;            // prescaled component, signed
    localparam int PROD_W = 30;            // component product, signed
    localparam int V_W    = 31;            // cross and dot product, signed
    localparam int N2_W   = 30;            // squared norm, unsigned
    localparam int SQ_W   = 2 * N2_W;      // product of squared norms
    localparam int ROOT_W = N2_W;          // integer square root
    localparam int X_W    = ROOT_W + 1;    // square root remainder
    localparam int PD_W   = ROOT_W + 2;    // P + d, signed
    localparam int VV_W   = 60;            // v_i * v_j, signed
    localparam int PV_W   = 62;            // (P + d) * v_i and d * (P + d), signed
    localparam int NUM_W  = 64;            // entry numerator, signed
    localparam int MAG_W  = NUM_W - 1;     // numerator magnitude
    localparam int DEN_W  = ROOT_W + PD_W - 1;
    localparam int REM_W  = DEN_W + 1;     // divider partial remainder
    localparam int OUT_W  = 16;
    localparam int LANES  = 9;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z = 2'd2;

    localparam int TARGET_Z_RESET = -16384;

    typedef struct packed {
        logic                  valid;
        logic                  deg;
        logic signed [V_W-1:0] d;
        logic signed [V_W-1:0] v0;
        logic signed [V_W-1:0] v1;
        logic signed [V_W-1:0] v2;
    } sqrt_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             deg;
        logic [LANES-1:0] sat;
        logic [LANES-1:0] neg;
    } div_ctl_t;

endpackage

>>> design/rbv_prescale.sv
// Per-vector prescale: shifts all three magnitudes right until the largest fits the limit.
module rbv_prescale #(
    parameter int CW = rbv_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic [2:0][CW-1:0]            comp,
    output logic [2:0][rbv_pkg::PC_W-1:0] scaled
);
    import rbv_pkg::*;

    localparam int KW = $clog2(CW + 1);

    logic [CW-1:0]   mag [3];
    logic [CW-1:0]   top;
    logic [KW-1:0]   shamt;
    logic [PC_W-1:0] sm  [3];

    always_comb
    begin
        top = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = comp[i][CW-1] ? CW'(-comp[i]) : comp[i];
            if (mag[i] > top)
                top = mag[i];
        end
        // smallest shift that brings the largest magnitude to at most the limit
        shamt = '0;
        for (int k = CW; k >= 0; k--)
        begin
            if ((top >> k) <= PRESCALE_LIMIT)
                shamt = KW'(k);
        end
        for (int i = 0; i < 3; i++)
        begin
            sm[i]     = PC_W'(mag[i] >> shamt);
            scaled[i] = comp[i][CW-1] ? PC_W'(-sm[i]) : sm[i];
        end
    end

endmodule

>>> design/rbv_sqrt_cell.sv
// One digit cell of the integer square root chain: retires two radicand bits per cycle while enabled.
module rbv_sqrt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  rbv_pkg::sqrt_ctl_t          ctl_in,
    input  logic [rbv_pkg::SQ_W-1:0]    q_in,
    input  logic [rbv_pkg::X_W-1:0]     x_in,
    input  logic [rbv_pkg::ROOT_W-1:0]  r_in,
    output rbv_pkg::sqrt_ctl_t          ctl_out,
    output logic [rbv_pkg::SQ_W-1:0]    q_out,
    output logic [rbv_pkg::X_W-1:0]     x_out,
    output logic [rbv_pkg::ROOT_W-1:0]  r_out
);
    import rbv_pkg::*;

    logic [X_W+1:0]   xs;
    logic [X_W+1:0]   trial;
    logic [X_W+1:0]   diff;
    logic             ge;
    logic [X_W-1:0]   x_next;
    sqrt_ctl_t        ctl_reg;
    logic [SQ_W-1:0]  q_reg;
    logic [X_W-1:0]   x_reg;
    logic [ROOT_W-1:0] r_reg;

    assign xs     = {x_in, q_in[SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_in, 2'b01};
    assign diff   = xs - trial;
    assign ge     = (xs >= trial);
    // remainder stays at most twice the partial root
    assign x_next = ge ? diff[X_W-1:0] : xs[X_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= {q_in[SQ_W-3:0], 2'b00};
            x_reg <= x_next;
            r_reg <= {r_in[ROOT_W-2:0], ge};
        end
    end

    assign ctl_out = ctl_reg;
    assign q_out   = q_reg;
    assign x_out   = x_reg;
    assign r_out   = r_reg;

endmodule

>>> design/rbv_div_cell.sv
// One quotient-bit cell of the nine-lane restoring divider chain.
module rbv_div_cell #(
    parameter int QW = rbv_pkg::FRACTION_BITS_DEF + 2
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  rbv_pkg::div_ctl_t                                   ctl_in,
    input  logic [rbv_pkg::DEN_W-1:0]                           den_in,
    input  logic [rbv_pkg::LANES-1:0][rbv_pkg::REM_W-1:0]       rem_in,
    input  logic [rbv_pkg::LANES-1:0][QW-1:0]                   q_in,
    output rbv_pkg::div_ctl_t                                   ctl_out,
    output logic [rbv_pkg::DEN_W-1:0]                           den_out,
    output logic [rbv_pkg::LANES-1:0][rbv_pkg::REM_W-1:0]       rem_out,
    output logic [rbv_pkg::LANES-1:0][QW-1:0]                   q_out
);
    import rbv_pkg::*;

    logic [LANES-1:0][REM_W-1:0] rem_next;
    logic [LANES-1:0][QW-1:0]    q_next;
    logic [REM_W-1:0]            sel;
    logic                        ge;
    div_ctl_t                    ctl_reg;
    logic [DEN_W-1:0]            den_reg;
    logic [LANES-1:0][REM_W-1:0] rem_reg;
    logic [LANES-1:0][QW-1:0]    q_reg;

    always_comb
    begin
        sel = '0;
        ge  = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            ge          = (rem_in[l] >= {1'b0, den_in});
            sel         = ge ? rem_in[l] - {1'b0, den_in} : rem_in[l];
            // sel < den, so the doubled remainder still fits
            rem_next[l] = {sel[REM_W-2:0], 1'b0};
            q_next[l]   = {q_in[l][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

>>> design/rotation_between_vectors.sv
// Rotation matrix between a source vector and a configured target vector (Rodrigues form).
//
// Channels: source_x/y/z enter on in_valid/in_ready; each transaction yields one
// transaction on out_valid/out_ready carrying m00..m22 (Q1.FRACTION_BITS) and degenerate.
// Target registers are written on cfg_valid/cfg_ready (always ready) by cfg_index;
// unknown indexes are ignored. Write them only while no transaction is in flight.
// Stages: 4 front stages, 30 square root cells, 4 stages forming the numerators,
// FRACTION_BITS + 2 divider cells, the output register.
// Throughput: one transaction per cycle while the skid is empty; every stage is a
// register that moves whenever the pipeline is not frozen.
// Stall: a two-entry output (register plus skid) absorbs a stalled receiver; when the
// skid is occupied the whole pipeline freezes and in_ready drops, nothing is lost.
// Reset: pipeline empties, target is (0, 0, -16384), no output is valid.
module rotation_between_vectors #(
    parameter int COMPONENT_WIDTH = rbv_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = rbv_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [COMPONENT_WIDTH-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0]   source_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   source_y,
    input  logic signed [COMPONENT_WIDTH-1:0]   source_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rbv_pkg::OUT_W-1:0]    m00,
    output logic signed [rbv_pkg::OUT_W-1:0]    m01,
    output logic signed [rbv_pkg::OUT_W-1:0]    m02,
    output logic signed [rbv_pkg::OUT_W-1:0]    m10,
    output logic signed [rbv_pkg::OUT_W-1:0]    m11,
    output logic signed [rbv_pkg::OUT_W-1:0]    m12,
    output logic signed [rbv_pkg::OUT_W-1:0]    m20,
    output logic signed [rbv_pkg::OUT_W-1:0]    m21,
    output logic signed [rbv_pkg::OUT_W-1:0]    m22,
    output logic                                degenerate
);
    import rbv_pkg::*;

    localparam int QW = FRACTION_BITS + 2;
    localparam int RW = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
    localparam logic [RW-1:0] ONE = RW'(1) << FRACTION_BITS;
    localparam logic [COMPONENT_WIDTH-1:0] TZ_RESET = COMPONENT_WIDTH'(TARGET_Z_RESET);

    // configuration
    logic [COMPONENT_WIDTH-1:0] target_x_reg, target_y_reg, target_z_reg;

    logic adv;
    logic inc;

    // prescale
    logic [2:0][COMPONENT_WIDTH-1:0] src_vec, tgt_vec;
    logic [2:0][PC_W-1:0]            pre_a, pre_b;

    logic                     s1_valid_reg;
    logic signed [PC_W-1:0]   s1_a_reg [3];
    logic signed [PC_W-1:0]   s1_b_reg [3];

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_ab_reg [3][3];
    logic signed [PROD_W-1:0] s2_aa_reg [3];
    logic signed [PROD_W-1:0] s2_bb_reg [3];

    logic                     s3_valid_reg;
    logic signed [V_W-1:0]    s3_v_reg [3];
    logic signed [V_W-1:0]    s3_d_reg;
    logic [N2_W-1:0]          s3_na2_reg, s3_nb2_reg;

    sqrt_ctl_t                s4_ctl_reg;
    sqrt_ctl_t                s4_ctl_next;
    logic [SQ_W-1:0]          s4_q_reg;

    sqrt_ctl_t                sq_ctl [ROOT_W+1];
    logic [SQ_W-1:0]          sq_q   [ROOT_W+1];
    logic [X_W-1:0]           sq_x   [ROOT_W+1];
    logic [ROOT_W-1:0]        sq_r   [ROOT_W+1];

    logic signed [PD_W-1:0]   pd_sum;
    logic                     s5_valid_reg, s5_deg_reg;
    logic [ROOT_W-1:0]        s5_p_reg;
    logic signed [PD_W-1:0]   s5_pd_reg;
    logic signed [V_W-1:0]    s5_d_reg;
    logic signed [V_W-1:0]    s5_v_reg [3];

    logic                     s6_valid_reg, s6_deg_reg;
    logic [DEN_W-1:0]         s6_den_reg;
    logic signed [VV_W-1:0]   s6_vv_reg [6];
    logic signed [PV_W-1:0]   s6_pv_reg [3];
    logic signed [PV_W-1:0]   s6_dp_reg;

    logic                     s7_valid_reg, s7_deg_reg;
    logic [DEN_W-1:0]         s7_den_reg;
    logic signed [NUM_W-1:0]  s7_num_reg [LANES];
    logic [NUM_W-1:0]         s7_abs [LANES];

    div_ctl_t                    s8_ctl_reg;
    div_ctl_t                    s8_ctl_next;
    logic [DEN_W-1:0]            s8_den_reg;
    logic [LANES-1:0][REM_W-1:0] s8_rem_reg;

    div_ctl_t                    dv_ctl [QW+1];
    logic [DEN_W-1:0]            dv_den [QW+1];
    logic [LANES-1:0][REM_W-1:0] dv_rem [QW+1];
    logic [LANES-1:0][QW-1:0]    dv_q   [QW+1];

    logic [QW:0]              rnd;
    logic [RW-1:0]            val;
    logic [RW-1:0]            sval;
    logic [OUT_W-1:0]         res [LANES];

    logic                     out_valid_reg, skid_full_reg;
    logic [OUT_W-1:0]         out_m_reg  [LANES];
    logic                     out_deg_reg;
    logic [OUT_W-1:0]         skid_m_reg [LANES];
    logic                     skid_deg_reg;

    assign adv       = !skid_full_reg;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            target_z_reg <= TZ_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET_X: target_x_reg <= cfg_data;
                REG_TARGET_Y: target_y_reg <= cfg_data;
                REG_TARGET_Z: target_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- front stages ----------------
    assign src_vec = {source_z, source_y, source_x};
    assign tgt_vec = {target_z_reg, target_y_reg, target_x_reg};

    rbv_prescale #(.CW(COMPONENT_WIDTH)) u_pre_a (.comp(src_vec), .scaled(pre_a));
    rbv_prescale #(.CW(COMPONENT_WIDTH)) u_pre_b (.comp(tgt_vec), .scaled(pre_b));

    always_comb
    begin
        s4_ctl_next.valid = s3_valid_reg;
        s4_ctl_next.deg   = (s3_na2_reg == '0) || (s3_nb2_reg == '0) ||
                            ((s3_v_reg[0] == '0) && (s3_v_reg[1] == '0) && (s3_v_reg[2] == '0));
        s4_ctl_next.d     = s3_d_reg;
        s4_ctl_next.v0    = s3_v_reg[0];
        s4_ctl_next.v1    = s3_v_reg[1];
        s4_ctl_next.v2    = s3_v_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_ctl_reg   <= '0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_ctl_reg   <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_ctl_reg   <= s4_ctl_next;
            s5_valid_reg <= sq_ctl[ROOT_W].valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_ctl_reg   <= s8_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_a_reg[i] <= $signed(pre_a[i]);
                s1_b_reg[i] <= $signed(pre_b[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    s2_ab_reg[i][j] <= PROD_W'(s1_a_reg[i]) * PROD_W'(s1_b_reg[j]);
                s2_aa_reg[i] <= PROD_W'(s1_a_reg[i]) * PROD_W'(s1_a_reg[i]);
                s2_bb_reg[i] <= PROD_W'(s1_b_reg[i]) * PROD_W'(s1_b_reg[i]);
            end
            s3_v_reg[0] <= V_W'(s2_ab_reg[1][2]) - V_W'(s2_ab_reg[2][1]);
            s3_v_reg[1] <= V_W'(s2_ab_reg[2][0]) - V_W'(s2_ab_reg[0][2]);
            s3_v_reg[2] <= V_W'(s2_ab_reg[0][1]) - V_W'(s2_ab_reg[1][0]);
            s3_d_reg    <= V_W'(s2_ab_reg[0][0]) + V_W'(s2_ab_reg[1][1])
                         + V_W'(s2_ab_reg[2][2]);
            s3_na2_reg  <= N2_W'(s2_aa_reg[0]) + N2_W'(s2_aa_reg[1]) + N2_W'(s2_aa_reg[2]);
            s3_nb2_reg  <= N2_W'(s2_bb_reg[0]) + N2_W'(s2_bb_reg[1]) + N2_W'(s2_bb_reg[2]);
            s4_q_reg    <= SQ_W'(s3_na2_reg) * SQ_W'(s3_nb2_reg);
        end
    end

    // ---------------- square root chain ----------------
    assign sq_ctl[0] = s4_ctl_reg;
    assign sq_q[0]   = s4_q_reg;
    assign sq_x[0]   = '0;
    assign sq_r[0]   = '0;

    for (genvar c = 0; c < ROOT_W; c++)
    begin : g_sqrt
        rbv_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (sq_ctl[c]),
            .q_in    (sq_q[c]),
            .x_in    (sq_x[c]),
            .r_in    (sq_r[c]),
            .ctl_out (sq_ctl[c+1]),
            .q_out   (sq_q[c+1]),
            .x_out   (sq_x[c+1]),
            .r_out   (sq_r[c+1])
        );
    end

    // ---------------- numerator stages ----------------
    assign pd_sum = $signed({2'b00, sq_r[ROOT_W]}) + PD_W'(sq_ctl[ROOT_W].d);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            s7_abs[l] = s7_num_reg[l][NUM_W-1] ? NUM_W'(-s7_num_reg[l]) : s7_num_reg[l];
        s8_ctl_next.valid = s7_valid_reg;
        s8_ctl_next.deg   = s7_deg_reg;
        for (int l = 0; l < LANES; l++)
        begin
            s8_ctl_next.neg[l] = s7_num_reg[l][NUM_W-1];
            s8_ctl_next.sat[l] = (s7_abs[l][MAG_W-1:0] >= {s7_den_reg, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // numerically antiparallel when P + d is not positive
            s5_deg_reg  <= sq_ctl[ROOT_W].deg || pd_sum[PD_W-1] || (pd_sum == '0);
            s5_p_reg    <= sq_r[ROOT_W];
            s5_pd_reg   <= pd_sum;
            s5_d_reg    <= sq_ctl[ROOT_W].d;
            s5_v_reg[0] <= sq_ctl[ROOT_W].v0;
            s5_v_reg[1] <= sq_ctl[ROOT_W].v1;
            s5_v_reg[2] <= sq_ctl[ROOT_W].v2;

            s6_deg_reg   <= s5_deg_reg;
            s6_den_reg   <= DEN_W'(s5_p_reg) * DEN_W'(s5_pd_reg[PD_W-2:0]);
            s6_vv_reg[0] <= VV_W'(s5_v_reg[0]) * VV_W'(s5_v_reg[0]);
            s6_vv_reg[1] <= VV_W'(s5_v_reg[0]) * VV_W'(s5_v_reg[1]);
            s6_vv_reg[2] <= VV_W'(s5_v_reg[0]) * VV_W'(s5_v_reg[2]);
            s6_vv_reg[3] <= VV_W'(s5_v_reg[1]) * VV_W'(s5_v_reg[1]);
            s6_vv_reg[4] <= VV_W'(s5_v_reg[1]) * VV_W'(s5_v_reg[2]);
            s6_vv_reg[5] <= VV_W'(s5_v_reg[2]) * VV_W'(s5_v_reg[2]);
            for (int i = 0; i < 3; i++)
                s6_pv_reg[i] <= PV_W'(s5_pd_reg) * PV_W'(s5_v_reg[i]);
            s6_dp_reg    <= PV_W'(s5_pd_reg) * PV_W'(s5_d_reg);

            // N = v v^T + (P + d) [v]x + d (P + d) I
            s7_deg_reg    <= s6_deg_reg;
            s7_den_reg    <= s6_den_reg;
            s7_num_reg[0] <= NUM_W'(s6_vv_reg[0]) + NUM_W'(s6_dp_reg);
            s7_num_reg[1] <= NUM_W'(s6_vv_reg[1]) - NUM_W'(s6_pv_reg[2]);
            s7_num_reg[2] <= NUM_W'(s6_vv_reg[2]) + NUM_W'(s6_pv_reg[1]);
            s7_num_reg[3] <= NUM_W'(s6_vv_reg[1]) + NUM_W'(s6_pv_reg[2]);
            s7_num_reg[4] <= NUM_W'(s6_vv_reg[3]) + NUM_W'(s6_dp_reg);
            s7_num_reg[5] <= NUM_W'(s6_vv_reg[4]) - NUM_W'(s6_pv_reg[0]);
            s7_num_reg[6] <= NUM_W'(s6_vv_reg[2]) - NUM_W'(s6_pv_reg[1]);
            s7_num_reg[7] <= NUM_W'(s6_vv_reg[4]) + NUM_W'(s6_pv_reg[0]);
            s7_num_reg[8] <= NUM_W'(s6_vv_reg[5]) + NUM_W'(s6_dp_reg);

            s8_den_reg <= s7_den_reg;
            for (int l = 0; l < LANES; l++)
                s8_rem_reg[l] <= s7_abs[l][REM_W-1:0];
        end
    end

    // ---------------- divider chain ----------------
    assign dv_ctl[0] = s8_ctl_reg;
    assign dv_den[0] = s8_den_reg;
    assign dv_rem[0] = s8_rem_reg;
    assign dv_q[0]   = '0;

    for (genvar c = 0; c < QW; c++)
    begin : g_div
        rbv_div_cell #(.QW(QW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (dv_ctl[c]),
            .den_in  (dv_den[c]),
            .rem_in  (dv_rem[c]),
            .q_in    (dv_q[c]),
            .ctl_out (dv_ctl[c+1]),
            .den_out (dv_den[c+1]),
            .rem_out (dv_rem[c+1]),
            .q_out   (dv_q[c+1])
        );
    end

    // round half away from zero, saturate to one, restore sign
    always_comb
    begin
        rnd  = '0;
        val  = '0;
        sval = '0;
        for (int l = 0; l < LANES; l++)
        begin
            rnd  = ({1'b0, dv_q[QW][l]} + (QW+1)'(1)) >> 1;
            val  = RW'(rnd);
            if (dv_ctl[QW].sat[l] || (val > ONE))
                val = ONE;
            sval = dv_ctl[QW].neg[l] ? RW'(-val) : val;
            if (dv_ctl[QW].deg)
                res[l] = ((l % 4) == 0) ? ONE[OUT_W-1:0] : '0;
            else
                res[l] = sval[OUT_W-1:0];
        end
    end

    // ---------------- output register and skid ----------------
    assign inc = dv_ctl[QW].valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_full_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
                out_valid_reg <= inc;
        end
        else if (inc)
            skid_full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_full_reg)
            begin
                out_m_reg   <= skid_m_reg;
                out_deg_reg <= skid_deg_reg;
            end
            else if (inc)
            begin
                out_m_reg   <= res;
                out_deg_reg <= dv_ctl[QW].deg;
            end
        end
        else if (inc)
        begin
            skid_m_reg   <= res;
            skid_deg_reg <= dv_ctl[QW].deg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign m00        = out_m_reg[0];
    assign m01        = out_m_reg[1];
    assign m02        = out_m_reg[2];
    assign m10        = out_m_reg[3];
    assign m11        = out_m_reg[4];
    assign m12        = out_m_reg[5];
    assign m20        = out_m_reg[6];
    assign m21        = out_m_reg[7];
    assign m22        = out_m_reg[8];
    assign degenerate = out_deg_reg;

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a transaction while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without a stalled output");

    a_degenerate_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_deg_reg) |->
            (m01 == '0) && (m02 == '0) && (m10 == '0) &&
            (m12 == '0) && (m20 == '0) && (m21 == '0))
        else $error("degenerate result is not the identity");

endmodule

>>> bench/rotation_between_vectors_test.sv
// Self-checking testbench for the rotation matrix between a source vector and a target vector.
module rotation_between_vectors_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int ONE_Q = 1 << FRACTION_BITS_DEF;
    localparam int LATENCY = FRACTION_BITS_DEF + 41;

    typedef struct {
        logic signed [OUT_W-1:0] m[9];
        logic                    deg;
    } rotation_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] source_x = '0, source_y = '0, source_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic degenerate;

    rotation_between_vectors dut (.*);

    always #5 clk = ~clk;

    // target register copy used by the predictor
    logic signed [15:0] tgt[3];
    rotation_t expected_rotations[$];
    int errors = 0;
    bit idle_on = 1'b1;

    function automatic void prescale_vec(inout longint c[3]);
        longint unsigned mag[3];
        longint unsigned top = 0;
        int k = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > top) top = mag[i];
        end
        while ((top >> k) > PRESCALE_LIMIT) k++;
        for (int i = 0; i < 3; i++)
            c[i] = c[i] < 0 ? -longint'(mag[i] >> k) : longint'(mag[i] >> k);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned q);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > q) b >>= 2;
        while (b != 0) begin
            if (q >= r + b) begin
                q -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // rounded |n| * 2^F / den, saturated at one, sign of n
    function automatic longint q_ratio(longint n, longint unsigned den);
        longint unsigned mag = n < 0 ? -n : n;
        longint unsigned acc = mag / den;
        longint unsigned rem = mag % den;
        if (acc >= 2) begin
            acc = ONE_Q;
        end else begin
            for (int i = 0; i < FRACTION_BITS_DEF; i++) begin
                rem <<= 1;
                acc <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    acc |= 1;
                end
            end
            rem <<= 1;
            if (rem >= den) acc += 1;
            if (acc > ONE_Q) acc = ONE_Q;
        end
        return n < 0 ? -longint'(acc) : longint'(acc);
    endfunction

    function automatic rotation_t predict_rotation(logic signed [15:0] sx, logic signed [15:0] sy,
                                                   logic signed [15:0] sz);
        rotation_t r;
        longint a[3], b[3], v[3], sk[3][3];
        longint d, pd, n;
        longint unsigned na2, nb2, p, den;
        a[0] = sx; a[1] = sy; a[2] = sz;
        for (int i = 0; i < 3; i++) b[i] = tgt[i];
        prescale_vec(a);
        prescale_vec(b);
        v[0] = a[1] * b[2] - a[2] * b[1];
        v[1] = a[2] * b[0] - a[0] * b[2];
        v[2] = a[0] * b[1] - a[1] * b[0];
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        na2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        nb2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        p = 0;
        pd = 0;
        if (na2 != 0 && nb2 != 0) begin
            p = isqrt(na2 * nb2);
            pd = longint'(p) + d;
        end
        if (na2 == 0 || nb2 == 0 || (v[0] == 0 && v[1] == 0 && v[2] == 0) || pd <= 0) begin
            for (int i = 0; i < 9; i++) r.m[i] = OUT_W'((i % 4 == 0) ? ONE_Q : 0);
            r.deg = 1'b1;
            return r;
        end
        sk[0][0] = 0;     sk[0][1] = -v[2]; sk[0][2] = v[1];
        sk[1][0] = v[2];  sk[1][1] = 0;     sk[1][2] = -v[0];
        sk[2][0] = -v[1]; sk[2][1] = v[0];  sk[2][2] = 0;
        den = p * longint'(pd);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                n = v[i] * v[j] + pd * sk[i][j];
                if (i == j) n += d * pd;
                r.m[i * 3 + j] = OUT_W'(q_ratio(n, den));
            end
        r.deg = 1'b0;
        return r;
    endfunction

    task automatic idle_burst();
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            idle_burst();
        end
        in_valid <= 1'b1;
        source_x <= x;
        source_y <= y;
        source_z <= z;
        do @(posedge clk); while (!in_ready);
        expected_rotations.insert(expected_rotations.size(), predict_rotation(x, y, z));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_rotations.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // writes all three targets, then an unused index that must be ignored
    task automatic set_target(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
        logic signed [15:0] vals[4];
        logic [CFG_IDX_W-1:0] idx[4];
        vals = '{x, y, z, 16'sh5a5a};
        idx = '{REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z, REG_UNUSED};
        drain();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            if (i < 3) tgt[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_target();
        send_vector(0, 0, 0);
        send_vector(0, 0, -5);
        send_vector(0, 0, 16384);
        send_vector(16384, 0, 0);
        send_vector(0, 32767, 0);
        send_vector(-32768, -32768, -32768);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, 32767, 1);
        send_vector(1, 0, 0);
        send_vector(1, 1, -32768);
        send_vector(-1, 0, 1);
    endtask

    task automatic test_target_extremes();
        set_target(32767, 32767, 32767);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, -32768, -32768);
        send_vector(-32768, 32767, 0);
        send_vector(3, -7, 11);
        set_target(-32768, -32768, -32768);
        send_vector(1, 2, 3);
        send_vector(32767, -32768, 100);
        set_target(0, 0, 0);
        send_vector(5, 6, 7);
        send_vector(-32768, 0, 32767);
        set_target(1, 0, 0);
        send_vector(-1, 0, 0);
        send_vector(0, 1, 0);
        send_vector(0, 0, 1);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return 16'(int'($urandom_range(0, 200)) - 100);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random();
        logic signed [15:0] x, y, z;
        int sc;
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) set_target(0, 0, -16384);
            else set_target(rand_comp(), rand_comp(), rand_comp());
            if (ph == 4) idle_on = 1'b0;
            for (int i = 0; i < 100; i++) begin
                case ($urandom_range(0, 4))
                    0: begin
                        // near the target direction or its opposite
                        sc = $urandom_range(0, 1) ? 1 : -1;
                        x = 16'(sc * (tgt[0] >>> $urandom_range(0, 3))
                                + int'($urandom_range(0, 2)) - 1);
                        y = 16'(sc * (tgt[1] >>> $urandom_range(0, 3))
                                + int'($urandom_range(0, 2)) - 1);
                        z = 16'(sc * (tgt[2] >>> $urandom_range(0, 3))
                                + int'($urandom_range(0, 2)) - 1);
                    end
                    1: begin
                        x = 16'(int'($urandom_range(0, 4)) - 2);
                        y = 16'(int'($urandom_range(0, 4)) - 2);
                        z = 16'(int'($urandom_range(0, 4)) - 2);
                    end
                    default: begin
                        x = rand_comp();
                        y = rand_comp();
                        z = rand_comp();
                    end
                endcase
                send_vector(x, y, z);
            end
        end
    endtask

    // receiver stalls in bursts, steady ready in the last part
    initial begin
        @(posedge rst_n);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (idle_on) begin
                out_ready <= 1'b0;
                idle_burst();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_rotations.size() == 0) begin
                $display("%0t: unexpected result transaction", $realtime);
                errors++;
            end else begin
                rotation_t e;
                logic signed [OUT_W-1:0] got[9];
                e = expected_rotations.pop_front();
                got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
                for (int i = 0; i < 9; i++)
                    if (got[i] !== e.m[i]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $realtime,
                                 i / 3, i % 3, e.m[i], got[i]);
                        errors++;
                    end
                if (degenerate !== e.deg) begin
                    $display("%0t: degenerate expected %0b actual %0b", $realtime,
                             e.deg, degenerate);
                    errors++;
                end
            end
        end
    end

    initial begin
        tgt = '{16'sd0, 16'sd0, -16'sd16384};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_target();
        test_target_extremes();
        test_random();
        drain();
        if (errors == 0)
            $display("rotation_between_vectors test passed");
        else
            $display("rotation_between_vectors test failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("rotation_between_vectors test failed");
        $finish;
    end

endmodule
